[hw/rtl/mspc_pkg.sv]
package mspc_pkg;

	localparam int CHANNELS    = 4;
	localparam int CH_W        = 2;
	localparam int DRIVE_LIMIT = 900;
	localparam int FRAC_OUT    = 22;
	localparam int BRAKE_CMP   = 1000;
	localparam int MS_PER_S    = 1000;

	localparam int SPEED_W = 16;
	localparam int GAIN_W  = 16;
	localparam int MS_W    = 16;
	localparam int ZERO_W  = 10;
	localparam int DIRS_W  = 8;
	localparam int ERR_W   = 17;
	localparam int DIFF_W  = 18;
	localparam int INT_W   = 24;
	localparam int ACC_W   = 50;
	localparam int DPART_W = 45;
	localparam int SUM_W   = 46;
	localparam int MUL_A_W = 45;
	localparam int MUL_P_W = MUL_A_W + GAIN_W;
	localparam int MUL_CNT_W = $clog2(GAIN_W + 1);
	localparam int DIV_N_W = 48;
	localparam int DIV_D_W = 16;
	localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);
	localparam int XM_W    = 33;
	localparam int Y_W     = 34;
	localparam int MAG_W   = 10;
	localparam int DRIVE_W = 11;
	localparam int CMP_W   = 10;

	localparam int ILIM_I = DRIVE_LIMIT * 8192;
	localparam logic [XM_W-1:0] OLIM = XM_W'(DRIVE_LIMIT) << FRAC_OUT;

	typedef enum logic [2:0] {
		MODE_FREE, MODE_SEND, MODE_SEND_PRESS, MODE_SLOW,
		MODE_PULL, MODE_STOP, MODE_LESS, MODE_OVER
	} motion_t;

	typedef enum logic [2:0] {
		CFG_KP, CFG_KI, CFG_KD, CFG_ZERO, CFG_DIR
	} cfg_idx_t;

	localparam logic KIND_CMD  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [1:0] DIR_OFF   = 2'd0;
	localparam logic [1:0] DIR_PLUS  = 2'd1;
	localparam logic [1:0] DIR_MINUS = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_IMUL1, ST_IMUL2, ST_IDIV, ST_DMUL1, ST_DMUL2,
		ST_DDIV, ST_SUM, ST_PMUL, ST_OUT
	} state_t;

	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [GAIN_W-1:0]  b;
	} mul_req_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] n;
		logic [DIV_D_W-1:0] d;
	} div_req_t;

	function automatic logic signed [ERR_W-1:0] target_q6(motion_t m);
		logic signed [ERR_W-1:0] t;
		case (m)
			MODE_SEND:       t = ERR_W'(50 * 64);
			MODE_SEND_PRESS: t = ERR_W'(20 * 64);
			MODE_SLOW:       t = ERR_W'(3 * 64);
			MODE_PULL:       t = ERR_W'(-50 * 64);
			MODE_LESS:       t = ERR_W'(10 * 64);
			MODE_OVER:       t = ERR_W'(-10 * 64);
			default:         t = '0;
		endcase
		return t;
	endfunction

endpackage

[hw/rtl/mspc_mul.sv]
module mspc_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mspc_pkg::mul_req_t             req,
	output logic                           done,
	output logic [mspc_pkg::MUL_P_W-1:0]   p
);
	import mspc_pkg::*;

	logic [MUL_P_W-1:0]   acc_q;
	logic [MUL_P_W-1:0]   mcand_q;
	logic [GAIN_W-1:0]    mplier_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= MUL_CNT_W'(GAIN_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MUL_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q    <= '0;
			mcand_q  <= MUL_P_W'(req.a);
			mplier_q <= req.b;
		end else if (run_q) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

[hw/rtl/mspc_div.sv]
module mspc_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mspc_pkg::div_req_t             req,
	output logic                           done,
	output logic [mspc_pkg::DIV_N_W-1:0]   quo
);
	import mspc_pkg::*;

	logic [DIV_N_W-1:0]   dvd_q;
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_D_W-1:0]   dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [DIV_D_W:0]     shifted;
	logic [DIV_D_W:0]     trial;
	logic                 ge;

	always_comb begin
		shifted = {rem_q, dvd_q[DIV_N_W-1]};
		ge      = shifted >= {1'b0, dvs_q};
		trial   = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(DIV_N_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.n;
			rem_q <= '0;
			dvs_q <= req.d;
		end else if (run_q) begin
			rem_q <= ge ? trial[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
			dvd_q <= {dvd_q[DIV_N_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = dvd_q;

endmodule

[hw/rtl/motor_speed_pi_controller_unit.sv]
// Channel   Handshake              Beat contents
// in        in_valid / in_ready    kind, channel, motion_code, hold_ms,
//                                  measured_speed, elapsed_ms
// out       out_valid / out_ready  out_channel, drive_value, forward_compare,
//                                  reverse_compare, motion_now
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// A command beat leaves the sequencer idle, so in_ready stays high; a tick in
// free or stop mode goes straight to the output state. An active tick runs
// five 16-step passes of the shared shift-add multiplier and two 48-step
// passes of the restoring divider (one divider pass when elapsed_ms is zero).
// A finished result waits in the output register while the next beat enters.
// Reset clears gains to their defaults and every channel to free mode.
module motor_speed_pi_controller_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 kind,
	input  logic [1:0]                           channel,
	input  logic [2:0]                           motion_code,
	input  logic [15:0]                          hold_ms,
	input  logic signed [15:0]                   measured_speed,
	input  logic [15:0]                          elapsed_ms,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           out_channel,
	output logic signed [10:0]                   drive_value,
	output logic [9:0]                           forward_compare,
	output logic [9:0]                           reverse_compare,
	output logic [2:0]                           motion_now,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [2:0]                           cfg_index,
	input  logic [15:0]                          cfg_data
);
	import mspc_pkg::*;

	// configuration
	logic [GAIN_W-1:0] kp_q, ki_q, kd_q;
	logic [ZERO_W-1:0] zero_q;
	logic [DIRS_W-1:0] dir_q;

	// per-channel state
	logic signed [INT_W-1:0] integ_q [CHANNELS];
	logic signed [ERR_W-1:0] prev_q  [CHANNELS];
	motion_t                 mode_q  [CHANNELS];
	logic [MS_W-1:0]         hold_q  [CHANNELS];

	// item in flight
	state_t                  state_q, state_d;
	logic [CH_W-1:0]         chan_q;
	logic [MS_W-1:0]         ms_q;
	logic signed [ERR_W-1:0] err_q;
	logic                    err_neg_q;
	logic [ERR_W-1:0]        diff_abs_q;
	logic                    diff_neg_q;
	logic signed [INT_W-1:0] integ_new_q;
	logic signed [DPART_W-1:0] dpart_q;
	logic                    sum_neg_q;
	motion_t                 mode_now_q;
	logic [MAG_W-1:0]        mag_q;
	logic                    neg_q;

	// output register
	logic                    out_valid_q;
	logic [CH_W-1:0]         out_ch_q;
	logic signed [DRIVE_W-1:0] drive_q;
	logic [CMP_W-1:0]        fwd_q, rev_q;
	motion_t                 motion_q;

	mul_req_t                mul_req;
	div_req_t                div_req;
	logic                    mul_done, div_done;
	logic [MUL_P_W-1:0]      mul_p;
	logic [DIV_N_W-1:0]      div_quo;

	logic                    accept, ch_ok, timed_out, active;
	motion_t                 mode_t;
	logic signed [ERR_W-1:0] err_in;
	logic [ERR_W-1:0]        err_abs;
	logic signed [DIFF_W-1:0] diff_in;
	logic [DIFF_W-1:0]       diff_abs;
	logic signed [ACC_W-1:0] q_s, integ_full;
	logic signed [INT_W-1:0] integ_cl;
	logic signed [DPART_W-1:0] dq_s;
	logic signed [SUM_W-1:0] sum;
	logic [SUM_W-1:0]        sum_abs;
	logic [XM_W-1:0]         xm;
	logic [Y_W-1:0]          y, y_cl;
	logic [1:0]              dcode;
	logic [MAG_W-1:0]        mag_fin;
	logic                    neg_fin;
	logic                    out_free;

	mspc_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .done(mul_done), .p(mul_p));
	mspc_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .done(div_done), .quo(div_quo));

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// front end: timeout check and error from the live beat
	always_comb begin
		ch_ok     = int'(channel) < CHANNELS;
		timed_out = hold_q[channel] <= elapsed_ms;
		mode_t    = timed_out ? MODE_FREE : mode_q[channel];
		active    = (mode_t != MODE_FREE) && (mode_t != MODE_STOP);
		err_in    = ERR_W'(measured_speed) - target_q6(mode_t);
		err_abs   = err_in[ERR_W-1] ? ERR_W'(-err_in) : ERR_W'(err_in);
		diff_in   = DIFF_W'(err_in) - DIFF_W'(prev_q[channel]);
		diff_abs  = diff_in[DIFF_W-1] ? DIFF_W'(-diff_in) : DIFF_W'(diff_in);
	end

	// integral update, derivative sign, PID sum
	always_comb begin
		q_s = signed'(ACC_W'(div_quo));
		if (err_neg_q)
			q_s = -q_s;
		integ_full = ACC_W'(integ_q[chan_q]) + q_s;
		if (integ_full > ACC_W'(ILIM_I))
			integ_cl = INT_W'(ILIM_I);
		else if (integ_full < ACC_W'(-ILIM_I))
			integ_cl = INT_W'(-ILIM_I);
		else
			integ_cl = integ_full[INT_W-1:0];
		dq_s = signed'(div_quo[DPART_W-1:0]);
		if (diff_neg_q)
			dq_s = -dq_s;
		sum = (SUM_W'(err_q) <<< 8) + SUM_W'(integ_new_q) + SUM_W'(dpart_q);
		sum_abs = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
	end

	// output clamp, direction, dead band with offset, drive clamp
	always_comb begin
		xm    = (mul_p > MUL_P_W'(OLIM)) ? OLIM : mul_p[XM_W-1:0];
		dcode = dir_q[{chan_q, 1'b0} +: 2];
		if (xm > (XM_W'(1) << FRAC_OUT))
			y = Y_W'(xm) + (Y_W'(zero_q) << FRAC_OUT);
		else
			y = '0;
		y_cl    = (y > Y_W'(OLIM)) ? Y_W'(OLIM) : y;
		mag_fin = y_cl[FRAC_OUT +: MAG_W];
		if (dcode != DIR_PLUS && dcode != DIR_MINUS)
			mag_fin = '0;
		neg_fin = sum_neg_q ^ (dcode == DIR_MINUS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// sequencer: issue each unit pass as the previous one completes
	always_comb begin
		state_d       = state_q;
		mul_req.start = 1'b0;
		mul_req.a     = '0;
		mul_req.b     = '0;
		div_req.start = 1'b0;
		div_req.n     = '0;
		div_req.d     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && ch_ok && kind == KIND_TICK) begin
					if (active) begin
						state_d       = ST_IMUL1;
						mul_req.start = 1'b1;
						mul_req.a     = MUL_A_W'(err_abs);
						mul_req.b     = ki_q;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_IMUL1: begin
				if (mul_done) begin
					state_d       = ST_IMUL2;
					mul_req.start = 1'b1;
					mul_req.a     = mul_p[MUL_A_W-1:0];
					mul_req.b     = ms_q;
				end
			end
			ST_IMUL2: begin
				if (mul_done) begin
					state_d       = ST_IDIV;
					div_req.start = 1'b1;
					div_req.n     = mul_p[DIV_N_W-1:0];
					div_req.d     = DIV_D_W'(MS_PER_S);
				end
			end
			ST_IDIV: begin
				if (div_done) begin
					state_d       = ST_DMUL1;
					mul_req.start = 1'b1;
					mul_req.a     = MUL_A_W'(diff_abs_q);
					mul_req.b     = kd_q;
				end
			end
			ST_DMUL1: begin
				if (mul_done) begin
					state_d       = ST_DMUL2;
					mul_req.start = 1'b1;
					mul_req.a     = mul_p[MUL_A_W-1:0];
					mul_req.b     = GAIN_W'(MS_PER_S);
				end
			end
			ST_DMUL2: begin
				if (mul_done) begin
					if (ms_q == '0) begin
						state_d = ST_SUM;
					end else begin
						state_d       = ST_DDIV;
						div_req.start = 1'b1;
						div_req.n     = mul_p[DIV_N_W-1:0];
						div_req.d     = ms_q;
					end
				end
			end
			ST_DDIV: begin
				if (div_done)
					state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d       = ST_PMUL;
				mul_req.start = 1'b1;
				mul_req.a     = sum_abs[MUL_A_W-1:0];
				mul_req.b     = kp_q;
			end
			ST_PMUL: begin
				if (mul_done)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration writes and per-channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= GAIN_W'(512);
			ki_q   <= GAIN_W'(2560);
			kd_q   <= '0;
			zero_q <= ZERO_W'(500);
			dir_q  <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				integ_q[i] <= '0;
				prev_q[i]  <= '0;
				mode_q[i]  <= MODE_FREE;
				hold_q[i]  <= '0;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_KP:   kp_q   <= cfg_data;
					CFG_KI:   ki_q   <= cfg_data;
					CFG_KD:   kd_q   <= cfg_data;
					CFG_ZERO: zero_q <= cfg_data[ZERO_W-1:0];
					CFG_DIR:  dir_q  <= cfg_data[DIRS_W-1:0];
					default:  ;
				endcase
			end
			if (accept && ch_ok) begin
				if (kind == KIND_CMD) begin
					hold_q[channel] <= hold_ms;
					if (mode_q[channel] != motion_t'(motion_code)) begin
						mode_q[channel]  <= motion_t'(motion_code);
						integ_q[channel] <= '0;
						prev_q[channel]  <= '0;
					end
				end else begin
					// count the hold down; drop to free when spent
					hold_q[channel] <= timed_out ? '0 : hold_q[channel] - elapsed_ms;
					mode_q[channel] <= mode_t;
					if (!active) begin
						integ_q[channel] <= '0;
						prev_q[channel]  <= '0;
					end
				end
			end
			if (state_q == ST_IDIV && div_done) begin
				integ_q[chan_q] <= integ_cl;
				prev_q[chan_q]  <= err_q;
			end
		end
	end

	// item datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			chan_q     <= channel;
			ms_q       <= elapsed_ms;
			err_q      <= err_in;
			err_neg_q  <= err_in[ERR_W-1];
			diff_abs_q <= diff_abs[ERR_W-1:0];
			diff_neg_q <= diff_in[DIFF_W-1];
			mode_now_q <= mode_t;
			mag_q      <= '0;
			neg_q      <= 1'b0;
			dpart_q    <= '0;
		end
		if (state_q == ST_IDIV && div_done)
			integ_new_q <= integ_cl;
		if (state_q == ST_DDIV && div_done)
			dpart_q <= dq_s;
		if (state_q == ST_SUM)
			sum_neg_q <= sum[SUM_W-1];
		if (state_q == ST_PMUL && mul_done) begin
			mag_q <= mag_fin;
			neg_q <= neg_fin;
		end
	end

	// output register: hold the result until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_ch_q <= chan_q;
			motion_q <= mode_now_q;
			drive_q  <= neg_q ? -DRIVE_W'(mag_q) : DRIVE_W'(mag_q);
			if (mag_q == '0) begin
				fwd_q <= CMP_W'(BRAKE_CMP);
				rev_q <= CMP_W'(BRAKE_CMP);
			end else if (neg_q) begin
				fwd_q <= '0;
				rev_q <= CMP_W'(mag_q);
			end else begin
				fwd_q <= CMP_W'(mag_q);
				rev_q <= '0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_channel     = out_ch_q;
	assign drive_value     = drive_q;
	assign forward_compare = fwd_q;
	assign reverse_compare = rev_q;
	assign motion_now      = motion_q;

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive_value <= DRIVE_W'(DRIVE_LIMIT)
			&& drive_value >= -DRIVE_W'(DRIVE_LIMIT)))
		else $error("drive beyond limit");

	a_brake: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && drive_value == '0) |->
			(forward_compare == CMP_W'(BRAKE_CMP) && reverse_compare == CMP_W'(BRAKE_CMP)))
		else $error("zero drive without brake");

	a_idle_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (motion_now == MODE_FREE || motion_now == MODE_STOP)) |->
			drive_value == '0)
		else $error("drive in free or stop mode");

	a_units_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_req.start && div_req.start))
		else $error("both units started together");

endmodule
